@@ rtl/morse_key_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// Morse key decoder assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_DECODER_MACROS_SVH
`define MORSE_KEY_DECODER_MACROS_SVH

// same-cycle implication, muted while rst is high
`define MKD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("morse key decoder: assertion failed");

// next-cycle implication, muted while rst is high
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("morse key decoder: assertion failed");

`endif

@@ rtl/mkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Morse key decoder package
// Types, codes, reset values and the symbol table.
// ----------------------------------------------------------------------------
package mkd_pkg;

   localparam int TABLE_SLOTS           = 64;
   localparam int TABLE_ENTRIES_DEFAULT = 53;
   localparam int CSR_ADDR_WIDTH        = 5;
   localparam int CSR_DATA_WIDTH        = 32;

   localparam logic [2:0] MAX_SYMBOL_LEN  = 3'd6;
   localparam logic [2:0] MAX_COUNT       = 3'd7;
   localparam logic [7:0] TICK_MAX        = 8'd255;

   localparam logic [7:0] DAH_THRESHOLD_RESET  = 8'd15;
   localparam logic [7:0] GAP_TIMEOUT_RESET    = 8'd50;
   localparam logic [7:0] HOLD_CLEAR_RESET     = 8'd255;
   localparam logic [2:0] GAPS_PER_SPACE_RESET = 3'd4;

   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE  = 8'h08;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_UNKNOWN    = 8'h3F;

   typedef enum logic [1:0] {
      PH_WAIT     = 2'd0,
      PH_IDLE     = 2'd1,
      PH_DEBOUNCE = 2'd2,
      PH_PRESS    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_CLEAR = 2'd2
   } out_kind_type;

   typedef enum logic [1:0] {
      PREVIEW_NONE = 2'd0,
      PREVIEW_DIT  = 2'd1,
      PREVIEW_DAH  = 2'd2
   } preview_type;

   typedef enum logic [2:0] {
      INJ_NONE      = 3'd0,
      INJ_DIT       = 3'd1,
      INJ_DAH       = 3'd2,
      INJ_NEWLINE   = 3'd3,
      INJ_BACKSPACE = 3'd4
   } inject_type;

   typedef enum logic [2:0] {
      REG_ENABLE         = 3'd0,
      REG_DAH_THRESHOLD  = 3'd1,
      REG_GAP_TIMEOUT    = 3'd2,
      REG_HOLD_CLEAR     = 3'd3,
      REG_GAPS_PER_SPACE = 3'd4
   } reg_index_type;

   // element j sits at bit j, 1 = dah; len 0 marks an empty slot
   typedef struct packed {
      logic [2:0] len;
      logic [5:0] bits;
      logic [7:0] ch;
   } sym_entry_type;

   function automatic sym_entry_type sym_entry(input logic [5:0] idx);
      sym_entry_type e;
      case (idx)
         6'd0:  e = '{3'd2, 6'b000010, 8'h41}; // A
         6'd1:  e = '{3'd4, 6'b000001, 8'h42}; // B
         6'd2:  e = '{3'd4, 6'b000101, 8'h43}; // C
         6'd3:  e = '{3'd3, 6'b000001, 8'h44}; // D
         6'd4:  e = '{3'd1, 6'b000000, 8'h45}; // E
         6'd5:  e = '{3'd4, 6'b000100, 8'h46}; // F
         6'd6:  e = '{3'd3, 6'b000011, 8'h47}; // G
         6'd7:  e = '{3'd4, 6'b000000, 8'h48}; // H
         6'd8:  e = '{3'd2, 6'b000000, 8'h49}; // I
         6'd9:  e = '{3'd4, 6'b001110, 8'h4A}; // J
         6'd10: e = '{3'd3, 6'b000101, 8'h4B}; // K
         6'd11: e = '{3'd4, 6'b000010, 8'h4C}; // L
         6'd12: e = '{3'd2, 6'b000011, 8'h4D}; // M
         6'd13: e = '{3'd2, 6'b000001, 8'h4E}; // N
         6'd14: e = '{3'd3, 6'b000111, 8'h4F}; // O
         6'd15: e = '{3'd4, 6'b000110, 8'h50}; // P
         6'd16: e = '{3'd4, 6'b001011, 8'h51}; // Q
         6'd17: e = '{3'd3, 6'b000010, 8'h52}; // R
         6'd18: e = '{3'd3, 6'b000000, 8'h53}; // S
         6'd19: e = '{3'd1, 6'b000001, 8'h54}; // T
         6'd20: e = '{3'd3, 6'b000100, 8'h55}; // U
         6'd21: e = '{3'd4, 6'b001000, 8'h56}; // V
         6'd22: e = '{3'd3, 6'b000110, 8'h57}; // W
         6'd23: e = '{3'd4, 6'b001001, 8'h58}; // X
         6'd24: e = '{3'd4, 6'b001101, 8'h59}; // Y
         6'd25: e = '{3'd4, 6'b000011, 8'h5A}; // Z
         6'd26: e = '{3'd5, 6'b011110, 8'h31}; // 1
         6'd27: e = '{3'd5, 6'b011100, 8'h32}; // 2
         6'd28: e = '{3'd5, 6'b011000, 8'h33}; // 3
         6'd29: e = '{3'd5, 6'b010000, 8'h34}; // 4
         6'd30: e = '{3'd5, 6'b000000, 8'h35}; // 5
         6'd31: e = '{3'd5, 6'b000001, 8'h36}; // 6
         6'd32: e = '{3'd5, 6'b000011, 8'h37}; // 7
         6'd33: e = '{3'd5, 6'b000111, 8'h38}; // 8
         6'd34: e = '{3'd5, 6'b001111, 8'h39}; // 9
         6'd35: e = '{3'd5, 6'b011111, 8'h30}; // 0
         6'd36: e = '{3'd6, 6'b101010, 8'h2E}; // period
         6'd37: e = '{3'd6, 6'b110011, 8'h2C}; // comma
         6'd38: e = '{3'd6, 6'b001100, 8'h3F}; // question mark
         6'd39: e = '{3'd6, 6'b011110, 8'h27}; // apostrophe
         6'd40: e = '{3'd6, 6'b110101, 8'h21}; // exclamation
         6'd41: e = '{3'd5, 6'b001001, 8'h2F}; // slash
         6'd42: e = '{3'd5, 6'b001101, 8'h28}; // open paren
         6'd43: e = '{3'd6, 6'b101101, 8'h29}; // close paren
         6'd44: e = '{3'd5, 6'b000010, 8'h26}; // ampersand
         6'd45: e = '{3'd6, 6'b000111, 8'h3A}; // colon
         6'd46: e = '{3'd6, 6'b010101, 8'h3B}; // semicolon
         6'd47: e = '{3'd5, 6'b010001, 8'h3D}; // equals
         6'd48: e = '{3'd5, 6'b001010, 8'h2B}; // plus
         6'd49: e = '{3'd6, 6'b100001, 8'h2D}; // hyphen
         6'd50: e = '{3'd6, 6'b101100, 8'h5F}; // underscore
         6'd51: e = '{3'd6, 6'b010010, 8'h22}; // double quote
         6'd52: e = '{3'd6, 6'b010110, 8'h2A}; // asterisk
         default: e = '{3'd0, 6'b000000, 8'h00};
      endcase
      return e;
   endfunction

endpackage

@@ rtl/mkd_channels.sv @@
// ----------------------------------------------------------------------------
// Morse key decoder channels
// Valid/ready interfaces for the key sample and result transactions.
// ----------------------------------------------------------------------------
interface mkd_req_if;
   logic       valid;
   logic       ready;
   logic       key_pressed;
   logic [2:0] injected_key;

   modport source (output valid, key_pressed, injected_key, input ready);
   modport sink   (input valid, key_pressed, injected_key, output ready);
endinterface

interface mkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] char_code;
   logic       led_on;
   logic [1:0] element_preview;

   modport source (output valid, out_kind, char_code, led_on, element_preview,
                   input ready);
   modport sink   (input valid, out_kind, char_code, led_on, element_preview,
                   output ready);
endinterface

@@ rtl/mkd_symbol_lookup.sv @@
// ----------------------------------------------------------------------------
// Morse symbol lookup
// Parallel match of the current symbol against every table slot.
// ----------------------------------------------------------------------------
module mkd_symbol_lookup #(
   parameter int TABLE_ENTRIES = mkd_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic [5:0] element_bits,
   input  logic [2:0] element_count,
   output logic [7:0] char_code
);

   always_comb begin
      logic [5:0]             mask;
      mkd_pkg::sym_entry_type ent;
      for (int j = 0; j < 6; j++) begin
         mask[j] = (3'(j) < element_count);
      end
      char_code = mkd_pkg::CHAR_UNKNOWN;
      // walk down so the lowest matching slot wins
      for (int i = mkd_pkg::TABLE_SLOTS - 1; i >= 0; i--) begin
         ent = mkd_pkg::sym_entry(6'(i));
         if ((i < TABLE_ENTRIES) && (ent.len == element_count) &&
             (((ent.bits ^ element_bits) & mask) == 6'd0)) begin
            char_code = ent.ch;
         end
      end
      if ((element_count == 3'd0) || (element_count > mkd_pkg::MAX_SYMBOL_LEN)) begin
         char_code = mkd_pkg::CHAR_UNKNOWN;
      end
   end

endmodule

@@ rtl/morse_key_decoder.sv @@
// Latency: a result is valid the cycle after its key sample is accepted.
// Throughput: one sample per cycle; the output register is refilled in the
// same cycle it is taken, so input stalls only while a result waits.
// The symbol decode is a parallel compare against all table slots.
// Reset (synchronous) clears the decoder state, drops any pending result
// and returns the CSRs to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Morse key decoder
// Times key presses, assembles dit/dah symbols and emits ASCII characters.
// ----------------------------------------------------------------------------
module morse_key_decoder #(
   parameter int TABLE_ENTRIES = mkd_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   mkd_req_if.sink                             req_chan,
   mkd_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mkd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mkd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mkd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   // configuration
   logic       enable_ff;
   logic [7:0] dah_threshold_ff;
   logic [7:0] gap_timeout_ff;
   logic [7:0] hold_clear_ff;
   logic [2:0] gaps_per_space_ff;

   // decoder state
   mkd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in;
   logic [5:0] elem_bits_ff, elem_bits_in;
   logic [2:0] elem_count_ff, elem_count_in;
   logic [7:0] last_char_ff, last_char_in;
   logic [2:0] gap_count_ff, gap_count_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   mkd_pkg::out_kind_type    out_kind_ff, out_kind_in;
   logic [7:0]               char_code_ff, char_code_in;
   logic                     led_on_ff, led_on_in;
   mkd_pkg::preview_type     preview_ff, preview_in;

   logic       accept;
   logic       cfg_write;
   logic [2:0] reg_sel;
   logic [7:0] sym_char;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         dah_threshold_ff  <= mkd_pkg::DAH_THRESHOLD_RESET;
         gap_timeout_ff    <= mkd_pkg::GAP_TIMEOUT_RESET;
         hold_clear_ff     <= mkd_pkg::HOLD_CLEAR_RESET;
         gaps_per_space_ff <= mkd_pkg::GAPS_PER_SPACE_RESET;
      end else if (cfg_write) begin
         case (reg_sel)
            mkd_pkg::REG_ENABLE:         enable_ff         <= csr_pwdata[0];
            mkd_pkg::REG_DAH_THRESHOLD:  dah_threshold_ff  <= csr_pwdata[7:0];
            mkd_pkg::REG_GAP_TIMEOUT:    gap_timeout_ff    <= csr_pwdata[7:0];
            mkd_pkg::REG_HOLD_CLEAR:     hold_clear_ff     <= csr_pwdata[7:0];
            mkd_pkg::REG_GAPS_PER_SPACE: gaps_per_space_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         mkd_pkg::REG_ENABLE:         csr_prdata = 32'(enable_ff);
         mkd_pkg::REG_DAH_THRESHOLD:  csr_prdata = 32'(dah_threshold_ff);
         mkd_pkg::REG_GAP_TIMEOUT:    csr_prdata = 32'(gap_timeout_ff);
         mkd_pkg::REG_HOLD_CLEAR:     csr_prdata = 32'(hold_clear_ff);
         mkd_pkg::REG_GAPS_PER_SPACE: csr_prdata = 32'(gaps_per_space_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   mkd_symbol_lookup #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_lookup (
      .element_bits  (elem_bits_ff),
      .element_count (elem_count_ff),
      .char_code     (sym_char)
   );

   // a new transaction is taken whenever the result slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_comb begin
      logic       idle_now;
      logic       add_en;
      logic       add_dah;
      logic [7:0] press_tick;
      logic [7:0] idle_tick;
      logic [2:0] gap_next;

      phase_in      = phase_ff;
      tick_in       = tick_ff;
      elem_bits_in  = elem_bits_ff;
      elem_count_in = elem_count_ff;
      last_char_in  = last_char_ff;
      gap_count_in  = gap_count_ff;
      out_kind_in   = mkd_pkg::KIND_NONE;
      char_code_in  = 8'd0;
      preview_in    = mkd_pkg::PREVIEW_NONE;
      idle_now      = 1'b0;
      add_en        = 1'b0;
      add_dah       = 1'b0;
      press_tick    = (tick_ff == mkd_pkg::TICK_MAX) ? tick_ff : tick_ff + 8'd1;
      idle_tick     = 8'd0;
      gap_next      = 3'd0;

      if (enable_ff) begin
         case (phase_ff)
            mkd_pkg::PH_WAIT: begin
               if (!req_chan.key_pressed) begin
                  phase_in = mkd_pkg::PH_IDLE;
                  tick_in  = 8'd0;
                  idle_now = 1'b1;
               end
            end
            mkd_pkg::PH_IDLE: begin
               idle_now = 1'b1;
            end
            mkd_pkg::PH_DEBOUNCE: begin
               phase_in = mkd_pkg::PH_PRESS;
               tick_in  = 8'd0;
            end
            default: begin
               if (req_chan.key_pressed) begin
                  tick_in = press_tick;
                  if (press_tick >= hold_clear_ff) begin
                     out_kind_in   = mkd_pkg::KIND_CLEAR;
                     elem_bits_in  = 6'd0;
                     elem_count_in = 3'd0;
                     last_char_in  = mkd_pkg::CHAR_UNDERSCORE;
                     gap_count_in  = 3'd0;
                     phase_in      = mkd_pkg::PH_WAIT;
                  end else if (press_tick < dah_threshold_ff) begin
                     preview_in = mkd_pkg::PREVIEW_DIT;
                  end else begin
                     preview_in = mkd_pkg::PREVIEW_DAH;
                  end
               end else begin
                  add_en   = 1'b1;
                  add_dah  = (tick_ff >= dah_threshold_ff);
                  phase_in = mkd_pkg::PH_WAIT;
               end
            end
         endcase

         if (idle_now) begin
            if (req_chan.key_pressed) begin
               phase_in = mkd_pkg::PH_DEBOUNCE;
            end else begin
               idle_tick = (tick_in == mkd_pkg::TICK_MAX) ? tick_in : tick_in + 8'd1;
               tick_in   = idle_tick;
               case (req_chan.injected_key)
                  mkd_pkg::INJ_DIT, mkd_pkg::INJ_DAH: begin
                     add_en   = 1'b1;
                     add_dah  = (req_chan.injected_key == mkd_pkg::INJ_DAH);
                     phase_in = mkd_pkg::PH_WAIT;
                  end
                  mkd_pkg::INJ_NEWLINE: begin
                     out_kind_in   = mkd_pkg::KIND_CHAR;
                     char_code_in  = mkd_pkg::CHAR_NEWLINE;
                     last_char_in  = mkd_pkg::CHAR_NEWLINE;
                     elem_bits_in  = 6'd0;
                     elem_count_in = 3'd0;
                     phase_in      = mkd_pkg::PH_WAIT;
                  end
                  mkd_pkg::INJ_BACKSPACE: begin
                     // a partial symbol is dropped silently
                     if (elem_count_ff == 3'd0) begin
                        out_kind_in  = mkd_pkg::KIND_CHAR;
                        char_code_in = mkd_pkg::CHAR_BACKSPACE;
                     end
                     last_char_in  = mkd_pkg::CHAR_BACKSPACE;
                     elem_bits_in  = 6'd0;
                     elem_count_in = 3'd0;
                     phase_in      = mkd_pkg::PH_WAIT;
                  end
                  default: begin
                     if (idle_tick >= gap_timeout_ff) begin
                        if (elem_count_ff != 3'd0) begin
                           out_kind_in  = mkd_pkg::KIND_CHAR;
                           char_code_in = sym_char;
                           last_char_in = sym_char;
                           gap_count_in = 3'd0;
                        end else if ((last_char_ff != mkd_pkg::CHAR_SPACE) &&
                                     (last_char_ff != mkd_pkg::CHAR_NEWLINE) &&
                                     (last_char_ff != mkd_pkg::CHAR_BACKSPACE)) begin
                           gap_next = (gap_count_ff == mkd_pkg::MAX_COUNT) ?
                                      gap_count_ff : gap_count_ff + 3'd1;
                           gap_count_in = gap_next;
                           if (gap_next == gaps_per_space_ff) begin
                              out_kind_in  = mkd_pkg::KIND_CHAR;
                              char_code_in = mkd_pkg::CHAR_SPACE;
                              last_char_in = mkd_pkg::CHAR_SPACE;
                           end
                        end
                        elem_bits_in  = 6'd0;
                        elem_count_in = 3'd0;
                        phase_in      = mkd_pkg::PH_WAIT;
                     end
                  end
               endcase
            end
         end

         if (add_en) begin
            if ((elem_count_ff < mkd_pkg::MAX_SYMBOL_LEN) && add_dah) begin
               elem_bits_in = elem_bits_ff | (6'd1 << elem_count_ff);
            end
            if (elem_count_ff < mkd_pkg::MAX_COUNT) begin
               elem_count_in = elem_count_ff + 3'd1;
            end
            gap_count_in = 3'd0;
         end
      end

      led_on_in = enable_ff && ((phase_in == mkd_pkg::PH_DEBOUNCE) ||
                                (phase_in == mkd_pkg::PH_PRESS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= mkd_pkg::PH_WAIT;
         tick_ff       <= 8'd0;
         elem_bits_ff  <= 6'd0;
         elem_count_ff <= 3'd0;
         last_char_ff  <= mkd_pkg::CHAR_UNDERSCORE;
         gap_count_ff  <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            tick_ff       <= tick_in;
            elem_bits_ff  <= elem_bits_in;
            elem_count_ff <= elem_count_in;
            last_char_ff  <= last_char_in;
            gap_count_ff  <= gap_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_kind_ff  <= out_kind_in;
         char_code_ff <= char_code_in;
         led_on_ff    <= led_on_in;
         preview_ff   <= preview_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_kind        = out_kind_ff;
   assign rsp_chan.char_code       = char_code_ff;
   assign rsp_chan.led_on          = led_on_ff;
   assign rsp_chan.element_preview = preview_ff;

endmodule

@@ rtl/mkd_checker.sv @@
// ----------------------------------------------------------------------------
// Morse key decoder checker
// Port-level consistency checks on result transactions.
// ----------------------------------------------------------------------------
`include "morse_key_decoder_macros.svh"

module mkd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [1:0] out_kind,
   input logic [7:0] char_code,
   input logic       led_on,
   input logic [1:0] element_preview
);

   // only an emitted character carries a code
   `MKD_ASSERT_IMP(a_char_zero, clock, reset, rsp_valid && (out_kind != mkd_pkg::KIND_CHAR), char_code == 8'd0)

   // a hold clear ends timing: LED off, no preview
   `MKD_ASSERT_IMP(a_clear_quiet, clock, reset, rsp_valid && (out_kind == mkd_pkg::KIND_CLEAR), !led_on && (element_preview == mkd_pkg::PREVIEW_NONE))

   // a preview only shows mid-press, with the LED lit and nothing emitted
   `MKD_ASSERT_IMP(a_preview_press, clock, reset, rsp_valid && (element_preview != mkd_pkg::PREVIEW_NONE), led_on && (out_kind == mkd_pkg::KIND_NONE))

   // no result survives reset
   `MKD_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid)

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .out_kind        (rsp_chan.out_kind),
   .char_code       (rsp_chan.char_code),
   .led_on          (rsp_chan.led_on),
   .element_preview (rsp_chan.element_preview)
);
